FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

FILE: hw/rtl/ncpt_pkg.sv
// ----------------------------------------------------------------------------
// Nearest color pixel tracker package
// Shared widths, constants and types of the tracker modules.
// ----------------------------------------------------------------------------
package ncpt_pkg;

   localparam int COLOR_W = 8;
   localparam int POS_W   = 11;
   localparam int DIST_W  = 18;
   localparam int COUNT_W = 23;
   localparam int SQ_W    = 2 * COLOR_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIST_W;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BLUE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT   = 2'd3;

   localparam logic [DIST_W-1:0]  NEAR_LIMIT_RESET = DIST_W'(400);
   localparam logic [DIST_W-1:0]  DIST_ALL_ONES    = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [DIST_W-1:0]  near_limit_sq;
   } ncpt_cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] dist_sq;
      logic              near;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic              eof;
   } ncpt_item_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } ncpt_queue_status_type;

   function automatic logic [SQ_W-1:0] square_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

FILE: hw/rtl/nearest_color_pixel_tracker.sv
// ----------------------------------------------------------------------------
// Nearest color pixel tracker
// Takes one BGR pixel per clock cycle while the queue is not full and at each
// end of frame reports the column and row of the first pixel closest to the
// target color, that smallest squared distance, and how many pixels lay
// below the near limit. A front end forms the distance, the near flag and
// the position of each pixel in the cycle it is accepted and pushes it into
// a four-entry queue; the back end updates the running minimum and count one
// queued pixel per cycle, so the sustained rate is one pixel per clock; only
// a pixel that ends a frame waits in the queue while an earlier result is
// still pending. The frame result is loaded into the output register as its
// last pixel leaves the queue and is held there until taken. Configuration
// writes take effect on the next pixel accepted.
// ----------------------------------------------------------------------------
module nearest_color_pixel_tracker import ncpt_pkg::*; #(
   parameter int MAX_COLUMNS = 2048,
   parameter int MAX_ROWS    = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // pixel_blue, pixel_green, pixel_red
   input  logic                  req_tuser,  // end_of_line
   input  logic                  req_tlast,  // end_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,  // best_x, best_y, min_distance_sq,
                                             // near_count, zero pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ncpt_cfg_type          cfg_ff, cfg_in;
   ncpt_queue_status_type q_status;
   ncpt_item_type         push_item;
   ncpt_item_type         head_item;
   logic                  q_push;
   logic                  q_pop;
   logic [POS_W-1:0]      best_x;
   logic [POS_W-1:0]      best_y;
   logic [DIST_W-1:0]     min_dist;
   logic [COUNT_W-1:0]    near_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TARGET_RED:   cfg_in.red           = csr_data[COLOR_W-1:0];
            CSR_TARGET_GREEN: cfg_in.green         = csr_data[COLOR_W-1:0];
            CSR_TARGET_BLUE:  cfg_in.blue          = csr_data[COLOR_W-1:0];
            CSR_NEAR_LIMIT:   cfg_in.near_limit_sq = csr_data[DIST_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red           <= '0;
         cfg_ff.green         <= '0;
         cfg_ff.blue          <= '0;
         cfg_ff.near_limit_sq <= NEAR_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ncpt_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pix_valid (req_tvalid),
      .pix_ready (req_tready),
      .pix_blue  (req_tdata[7:0]),
      .pix_green (req_tdata[15:8]),
      .pix_red   (req_tdata[23:16]),
      .pix_eol   (req_tuser),
      .pix_eof   (req_tlast),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   ncpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   ncpt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_item      (head_item),
      .pop            (q_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_best_x     (best_x),
      .rsp_best_y     (best_y),
      .rsp_min_dist   (min_dist),
      .rsp_near_count (near_count)
   );

   assign rsp_tdata = {1'b0, near_count, min_dist, best_y, best_x};

endmodule

FILE: hw/rtl/ncpt_front.sv
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts pixels, tracks column and row, and forms the squared color distance.
// ----------------------------------------------------------------------------
module ncpt_front import ncpt_pkg::*; #(
   parameter int MAX_COLUMNS = 2048,
   parameter int MAX_ROWS    = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ncpt_cfg_type          cfg,
   input  logic                  pix_valid,
   output logic                  pix_ready,
   input  logic [COLOR_W-1:0]    pix_blue,
   input  logic [COLOR_W-1:0]    pix_green,
   input  logic [COLOR_W-1:0]    pix_red,
   input  logic                  pix_eol,
   input  logic                  pix_eof,
   input  ncpt_queue_status_type q_status,
   output logic                  q_push,
   output ncpt_item_type         q_item
);

   localparam int PosMax = (1 << POS_W) - 1;
   localparam int ColTop = (MAX_COLUMNS - 1 > PosMax) ? PosMax : MAX_COLUMNS - 1;
   localparam int RowTop = (MAX_ROWS - 1 > PosMax) ? PosMax : MAX_ROWS - 1;
   localparam logic [POS_W-1:0] ColBound = POS_W'(ColTop);
   localparam logic [POS_W-1:0] RowBound = POS_W'(RowTop);

   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [DIST_W-1:0] dist_sq;
   logic              accept;

   assign pix_ready = !q_status.full;
   assign accept    = pix_valid && pix_ready;
   assign q_push    = accept;

   always_comb begin
      dist_sq = DIST_W'(square_diff(pix_red, cfg.red))
              + DIST_W'(square_diff(pix_green, cfg.green))
              + DIST_W'(square_diff(pix_blue, cfg.blue));
      q_item.dist_sq = dist_sq;
      q_item.near    = (dist_sq < cfg.near_limit_sq);
      q_item.x       = col_ff;
      q_item.y       = row_ff;
      q_item.eof     = pix_eof;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         priority if (pix_eof) begin
            col_in = '0;
            row_in = '0;
         end else if (pix_eol) begin
            col_in = '0;
            if (row_ff < RowBound) begin
               row_in = row_ff + 1'b1;
            end
         end else if (col_ff < ColBound) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: hw/rtl/ncpt_queue.sv
// ----------------------------------------------------------------------------
// Tracker item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ncpt_queue import ncpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ncpt_item_type         push_item,
   input  logic                  pop,
   output ncpt_item_type         head_item,
   output ncpt_queue_status_type status
);

   ncpt_item_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign status.full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.head_valid = (count_ff != '0);
   assign head_item         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && status.full))
   `ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(pop && !status.head_valid))

endmodule

FILE: hw/rtl/ncpt_back.sv
// ----------------------------------------------------------------------------
// Tracker back end
// Keeps the running minimum and near count and issues the per-frame result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ncpt_back import ncpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ncpt_queue_status_type q_status,
   input  ncpt_item_type         head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [POS_W-1:0]      rsp_best_x,
   output logic [POS_W-1:0]      rsp_best_y,
   output logic [DIST_W-1:0]     rsp_min_dist,
   output logic [COUNT_W-1:0]    rsp_near_count
);

   logic [DIST_W-1:0]  min_ff, min_in, min_upd;
   logic [POS_W-1:0]   bx_ff, bx_in, bx_upd;
   logic [POS_W-1:0]   by_ff, by_in, by_upd;
   logic [COUNT_W-1:0] cnt_ff, cnt_in, cnt_upd;
   logic               out_valid_ff, out_valid_in;
   logic [POS_W-1:0]   out_x_ff, out_x_in;
   logic [POS_W-1:0]   out_y_ff, out_y_in;
   logic [DIST_W-1:0]  out_min_ff, out_min_in;
   logic [COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic               load;

   assign pop  = q_status.head_valid && !(head_item.eof && out_valid_ff && !rsp_ready);
   assign load = pop && head_item.eof;

   always_comb begin
      min_upd = min_ff;
      bx_upd  = bx_ff;
      by_upd  = by_ff;
      cnt_upd = cnt_ff;
      if (head_item.dist_sq < min_ff) begin
         min_upd = head_item.dist_sq;
         bx_upd  = head_item.x;
         by_upd  = head_item.y;
      end
      if (head_item.near && cnt_ff != COUNT_MAX) begin
         cnt_upd = cnt_ff + 1'b1;
      end

      min_in = min_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         if (head_item.eof) begin
            min_in = DIST_ALL_ONES;
            bx_in  = '0;
            by_in  = '0;
            cnt_in = '0;
         end else begin
            min_in = min_upd;
            bx_in  = bx_upd;
            by_in  = by_upd;
            cnt_in = cnt_upd;
         end
      end

      out_x_in   = load ? bx_upd : out_x_ff;
      out_y_in   = load ? by_upd : out_y_ff;
      out_min_in = load ? min_upd : out_min_ff;
      out_cnt_in = load ? cnt_upd : out_cnt_ff;
      priority if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= DIST_ALL_ONES;
         bx_ff        <= '0;
         by_ff        <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         bx_ff        <= bx_in;
         by_ff        <= by_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_min_ff <= out_min_in;
      out_cnt_ff <= out_cnt_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_best_x     = out_x_ff;
   assign rsp_best_y     = out_y_ff;
   assign rsp_min_dist   = out_min_ff;
   assign rsp_near_count = out_cnt_ff;

   `ASSERT_NEXT(a_min_falls, clock, reset, pop && !head_item.eof, min_ff <= $past(min_ff))
   `ASSERT_NEXT(a_cnt_grows, clock, reset, pop && !head_item.eof, cnt_ff >= $past(cnt_ff))
   `ASSERT_NEXT(a_frame_clear, clock, reset, load, min_ff == DIST_ALL_ONES && cnt_ff == '0)

endmodule
